// ----- rtl/mlpa_pkg.sv -----
// Shared types and codes for the multi-list page allocator.
`default_nettype none

package mlpa_pkg;

  // Page geometry
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PFN_W      = ADDR_W - PAGE_SHIFT;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SEED  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  // Register word index (paddr[2])
  typedef enum logic {
    REG_MEM_BASE = 1'b0,
    REG_MEM_TOP  = 1'b1
  } reg_idx_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WORK = 1'b1
  } state_t;

  // Request transaction
  typedef struct packed {
    logic [1:0]        operation;
    logic [2:0]        cpu_id;
    logic [1:0]        list_select;
    logic [ADDR_W-1:0] page_address;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
    logic [1:0]        served_list;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/mlpa_link_ram.sv -----
// Next-page link memory: one write port, one registered read port.
`default_nettype none

module mlpa_link_ram #(
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered and held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_list_page_allocator_core.sv -----
// Top level of the multi-list page allocator: LIFO free lists linked in a RAM.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | in_data  (mlpa_pkg::in_t)
//  out_    | output    | out_valid/out_stall| out_data (mlpa_pkg::out_t)
//  cfg_    | input     | APB psel/penable   | mem_base @ 0x0, mem_top @ 0x4
//
// Each transaction is accepted in S_IDLE, which picks the list and issues the link
// RAM read, and commits in S_WORK, which writes the list head (and link RAM for
// pushes) and loads the output register. The link RAM read is registered, so the
// head update waits for S_WORK.
// A new request is taken while the previous result still sits in the output
// register; the commit cycle waits while out_stall holds that register.
// Reset (rst_n low, synchronous) empties all lists; the link RAM needs no clearing.
`default_nettype none

module multi_list_page_allocator_core #(
  parameter int unsigned NUM_LISTS = 4,
  parameter int unsigned NUM_PAGES = 32768
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire mlpa_pkg::in_t                         in_data,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output mlpa_pkg::out_t                             out_data,
  // configuration port
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [mlpa_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire logic [mlpa_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic      [mlpa_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                       cfg_pready
);

  import mlpa_pkg::*;

  localparam int unsigned LW     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned PW     = $clog2(NUM_PAGES);
  localparam int unsigned LINK_W = PW + 1;

  // Reduce a 3-bit number modulo NUM_LISTS by repeated subtraction
  function automatic logic [LW-1:0] list_of(input logic [2:0] v);
    logic [4:0] r;
    r = {2'b00, v};
    for (int k = 0; k < 8; k++) begin
      if (r >= 5'(NUM_LISTS)) begin
        r = r - 5'(NUM_LISTS);
      end
    end
    return r[LW-1:0];
  endfunction

  // Configuration registers
  logic [ADDR_W-1:0] base_r, top_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      top_r  <= '0;
    end else if (cfg_wr) begin
      if (reg_idx_t'(cfg_paddr[2]) == REG_MEM_BASE) begin
        base_r <= cfg_pwdata;
      end else begin
        top_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (reg_idx_t'(cfg_paddr[2]) == REG_MEM_BASE) ? base_r : top_r;

  // List heads in flops
  logic [PW-1:0] head_pg_r [NUM_LISTS];
  logic          head_vld_r [NUM_LISTS];

  // Sequencer and job registers
  state_t        state_r, state_nxt;
  op_t           job_op_r;
  logic [LW-1:0] job_list_r, job_own_r;
  logic          job_ok_r;
  logic [PW-1:0] job_pn_r;
  logic [PW-1:0] job_hd_pg_r;
  logic          job_hd_vld_r;

  // Output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic accept, commit;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Request decode
  op_t               op;
  logic [LW-1:0]     own, sel_list, pick, tgt;
  logic              own_vld, any_vld;
  logic [PFN_W-1:0]  pfn_off;
  logic              addr_good;

  assign op       = op_t'(in_data.operation);
  assign own      = list_of(in_data.cpu_id);
  assign sel_list = list_of({1'b0, in_data.list_select});
  assign own_vld  = head_vld_r[own];

  // Steal search: highest non-empty list wins when own list is empty
  always_comb begin
    pick    = own;
    any_vld = own_vld;
    if (!own_vld) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (head_vld_r[i]) begin
          pick    = LW'(i);
          any_vld = 1'b1;
        end
      end
    end
  end

  // Address check and page number
  assign pfn_off   = in_data.page_address[ADDR_W-1:PAGE_SHIFT] - base_r[ADDR_W-1:PAGE_SHIFT];
  assign addr_good = (in_data.page_address[PAGE_SHIFT-1:0] == '0) &&
                     (in_data.page_address >= base_r) &&
                     (in_data.page_address < top_r) &&
                     ({1'b0, pfn_off} < (PFN_W+1)'(NUM_PAGES));

  always_comb begin
    case (op)
      OP_ALLOC: tgt = pick;
      OP_FREE:  tgt = own;
      OP_SEED:  tgt = sel_list;
      default:  tgt = '0;
    endcase
  end

  // Link RAM
  logic [LINK_W-1:0] rd_link;
  logic              ram_we;

  assign ram_we = commit && (job_op_r == OP_FREE || job_op_r == OP_SEED) && job_ok_r;

  mlpa_link_ram #(
    .DEPTH  (NUM_PAGES),
    .DATA_W (LINK_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (job_pn_r),
    .wr_data ({job_hd_vld_r, job_hd_pg_r}),
    .rd_en   (accept && (op == OP_ALLOC)),
    .rd_addr (head_pg_r[tgt]),
    .rd_data (rd_link)
  );

  // Job capture at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      job_op_r     <= op;
      job_list_r   <= tgt;
      job_own_r    <= own;
      job_ok_r     <= (op == OP_ALLOC) ? any_vld : addr_good;
      job_pn_r     <= pfn_off[PW-1:0];
      job_hd_pg_r  <= head_pg_r[tgt];
      job_hd_vld_r <= head_vld_r[tgt];
    end
  end

  // Sequencer, commit and result build
  always_comb begin
    state_nxt     = state_r;
    commit        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (!out_valid_r || !out_stall) begin
          commit        = 1'b1;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (job_op_r)
            OP_ALLOC: begin
              if (job_ok_r) begin
                out_data_nxt.granted_address =
                  {base_r[ADDR_W-1:PAGE_SHIFT] + PFN_W'(job_hd_pg_r), {PAGE_SHIFT{1'b0}}};
                out_data_nxt.status      = ST_OK;
                out_data_nxt.served_list = 2'(job_list_r);
              end else begin
                out_data_nxt.status      = ST_OOM;
                out_data_nxt.served_list = 2'(job_own_r);
              end
            end
            OP_FREE, OP_SEED: begin
              out_data_nxt.status      = job_ok_r ? ST_OK : ST_BAD;
              out_data_nxt.served_list = 2'(job_list_r);
            end
            default: begin
              out_data_nxt.status = ST_BAD;
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Head update: push links the page in, pop takes the stored link
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else if (commit && job_ok_r) begin
      if (job_op_r == OP_ALLOC) begin
        head_vld_r[job_list_r] <= rd_link[PW];
      end else if (job_op_r == OP_FREE || job_op_r == OP_SEED) begin
        head_vld_r[job_list_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && job_ok_r) begin
      if (job_op_r == OP_ALLOC) begin
        head_pg_r[job_list_r] <= rd_link[PW-1:0];
      end else if (job_op_r == OP_FREE || job_op_r == OP_SEED) begin
        head_pg_r[job_list_r] <= job_pn_r;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the multi-list page allocator core.

module tb_top;
  import mlpa_pkg::*;

  localparam int NUM_LISTS   = 4;
  localparam int NUM_PAGES   = 32768;
  localparam int IDLE_PCT    = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;

  // Tracks free lists, predicts each grant and checks it against the DUT
  class alloc_scoreboard;
    typedef struct packed {
      logic             valid;
      logic [PFN_W-1:0] page;
    } link_t;

    logic [31:0] mem_base;
    logic [31:0] mem_top;
    link_t       heads [NUM_LISTS];
    link_t       links [NUM_PAGES];
    out_t        expected_grants [$];
    int          errors;

    function new();
      mem_base = '0;
      mem_top  = '0;
      errors   = 0;
      foreach (heads[i]) heads[i] = '0;
      foreach (links[i]) links[i] = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_MEM_BASE) mem_base = val;
      else mem_top = val;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // Pop the head page of one list, if any
    function bit pop_list(int lst, output logic [PFN_W-1:0] pn);
      pn = '0;
      if (!heads[lst].valid) return 1'b0;
      if (heads[lst].page >= NUM_PAGES) begin
        heads[lst].valid = 1'b0;
        return 1'b0;
      end
      pn = heads[lst].page;
      heads[lst] = links[pn];
      return 1'b1;
    endfunction

    // Aligned, inside the window and within the link memory
    function bit page_ok(logic [31:0] addr, output logic [PFN_W-1:0] pn);
      pn = addr[31:PAGE_SHIFT] - mem_base[31:PAGE_SHIFT];
      return addr[PAGE_SHIFT-1:0] == '0 && addr >= mem_base && addr < mem_top &&
             pn < NUM_PAGES;
    endfunction

    // Apply one accepted request transaction and queue its grant
    function void note_request(in_t req);
      out_t             res;
      logic [1:0]       own;
      logic [1:0]       tgt;
      logic [PFN_W-1:0] pn;
      bit               got;
      res = '0;
      own = 2'(req.cpu_id % NUM_LISTS);
      case (op_t'(req.operation))
        OP_ALLOC: begin
          res.served_list = own;
          got = pop_list(own, pn);
          // steal from the highest other list downward
          for (int i = NUM_LISTS - 1; i >= 0 && !got; i--) begin
            if (i != own) begin
              got = pop_list(i, pn);
              if (got) res.served_list = 2'(i);
            end
          end
          if (got) begin
            res.granted_address = ((mem_base >> PAGE_SHIFT) + pn) << PAGE_SHIFT;
          end else begin
            res.status      = ST_OOM;
            res.served_list = own;
          end
        end
        OP_FREE, OP_SEED: begin
          tgt = (op_t'(req.operation) == OP_FREE) ? own : 2'(req.list_select % NUM_LISTS);
          res.served_list = tgt;
          if (page_ok(req.page_address, pn)) begin
            links[pn]  = heads[tgt];
            heads[tgt] = {1'b1, pn};
          end else begin
            res.status = ST_BAD;
          end
        end
        default: res.status = ST_BAD;
      endcase
      expected_grants.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Check one accepted result transaction against the oldest prediction
    function void check_grant(out_t got);
      out_t want;
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = expected_grants.pop_front();
      compare_field("granted_address", want.granted_address, got.granted_address);
      compare_field("status", want.status, got.status);
      compare_field("served_list", want.served_list, got.served_list);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  alloc_scoreboard board;
  bit              src_calm  = 1'b0;
  bit              sink_calm = 1'b0;
  int              hold_left = 0;
  int              quiet_cycles = 0;

  multi_list_page_allocator_core #(
    .NUM_LISTS(NUM_LISTS),
    .NUM_PAGES(NUM_PAGES)
  ) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !sink_calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_grant(out_data);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t make_req(op_t op, logic [2:0] cpu, logic [1:0] sel,
                                   logic [31:0] addr);
    in_t req;
    req.operation    = op;
    req.cpu_id       = cpu;
    req.list_select  = sel;
    req.page_address = addr;
    return req;
  endfunction

  // Mostly in-window pages, with some malformed addresses mixed in
  function automatic in_t random_request(logic [31:0] base, int span, int alloc_pct);
    in_t         req;
    int          r;
    logic [31:0] pfn;
    req.cpu_id      = 3'($urandom_range(7));
    req.list_select = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < alloc_pct) req.operation = OP_ALLOC;
    else if (r < alloc_pct + (100 - alloc_pct) / 2) req.operation = OP_FREE;
    else if (r < 97) req.operation = OP_SEED;
    else req.operation = OP_BAD;
    pfn = (base >> PAGE_SHIFT) + $urandom_range(span);
    case ($urandom_range(19))
      0: req.page_address = $urandom;
      1: req.page_address = (pfn << PAGE_SHIFT) | $urandom_range(4095, 1);
      2: req.page_address = ((base >> PAGE_SHIFT) - $urandom_range(3, 1)) << PAGE_SHIFT;
      3: req.page_address =
           ((base >> PAGE_SHIFT) + $urandom_range(NUM_PAGES + 8, NUM_PAGES - 8)) << PAGE_SHIFT;
      default: req.page_address = pfn << PAGE_SHIFT;
    endcase
    return req;
  endfunction

  // Offer one request transaction, with random gaps ahead of it
  task automatic issue_request(in_t req);
    @(negedge clk);
    while (!src_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      in_data.page_address <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
  endtask

  // One APB access; a read is checked against the given value
  task automatic cfg_access(bit write, reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= write ? data : '0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (write) begin
      board.set_reg(idx, data);
    end else if (cfg_prdata !== data) begin
      board.errors++;
      $display("%0t: register %s readback: expected 0x%0h, actual 0x%0h",
               $time, idx.name(), data, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Stop offering and wait until every grant has come back
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_window(logic [31:0] base, logic [31:0] top);
    settle_block();
    cfg_access(1'b1, REG_MEM_BASE, base);
    cfg_access(1'b1, REG_MEM_TOP, top);
    cfg_access(1'b0, REG_MEM_BASE, base);
    cfg_access(1'b0, REG_MEM_TOP, top);
  endtask

  task automatic run_phase(logic [31:0] base, logic [31:0] top, int span, int count,
                           int alloc_pct, bit calm, bit hold);
    program_window(base, top);
    src_calm  = calm;
    sink_calm = calm;
    if (hold) hold_left = HOLD_CYCLES;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) settle_block();
      issue_request(random_request(base, span, alloc_pct));
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  initial begin
    logic [31:0] rbase;
    int          rpages;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    board = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Small window: empty lists, window edges, stealing, double free
    program_window(32'h0010_0000, 32'h0010_8000);
    issue_request(make_req(OP_ALLOC, 3'd0, 2'd0, 32'h0));
    issue_request(make_req(OP_SEED, 3'd0, 2'd0, 32'h0010_0000));
    issue_request(make_req(OP_SEED, 3'd1, 2'd3, 32'h0010_7000));
    issue_request(make_req(OP_SEED, 3'd2, 2'd1, 32'h0010_8000));
    issue_request(make_req(OP_SEED, 3'd3, 2'd2, 32'h000F_F000));
    issue_request(make_req(OP_FREE, 3'd5, 2'd0, 32'h0010_0001));
    issue_request(make_req(OP_FREE, 3'd5, 2'd0, 32'h0010_1000));
    issue_request(make_req(OP_BAD, 3'd6, 2'd3, 32'h0010_2000));
    issue_request(make_req(OP_ALLOC, 3'd1, 2'd0, 32'h0));
    issue_request(make_req(OP_ALLOC, 3'd6, 2'd0, 32'h0));
    issue_request(make_req(OP_ALLOC, 3'd7, 2'd0, 32'h0));
    issue_request(make_req(OP_SEED, 3'd0, 2'd2, 32'h0010_2000));
    issue_request(make_req(OP_SEED, 3'd4, 2'd2, 32'h0010_2000));
    issue_request(make_req(OP_ALLOC, 3'd2, 2'd0, 32'h0));
    issue_request(make_req(OP_ALLOC, 3'd2, 2'd0, 32'h0));
    issue_request(make_req(OP_SEED, 3'd0, 2'd0, 32'h0010_3000));

    // Full address range; base moves while a page is still listed
    program_window(32'h0000_0000, 32'hFFFF_FFFF);
    issue_request(make_req(OP_ALLOC, 3'd4, 2'd0, 32'h0));
    issue_request(make_req(OP_SEED, 3'd0, 2'd1, 32'h07FF_F000));
    issue_request(make_req(OP_SEED, 3'd0, 2'd1, 32'h0800_0000));
    issue_request(make_req(OP_FREE, 3'd3, 2'd0, 32'hFFFF_F000));
    issue_request(make_req(OP_ALLOC, 3'd1, 2'd0, 32'h0));

    // Topmost page only
    program_window(32'hFFFF_F000, 32'hFFFF_FFFF);
    issue_request(make_req(OP_SEED, 3'd2, 2'd3, 32'hFFFF_F000));
    issue_request(make_req(OP_ALLOC, 3'd3, 2'd0, 32'h0));
    issue_request(make_req(OP_FREE, 3'd0, 2'd0, 32'h0000_0000));

    // Random phases over several windows
    run_phase(32'h0010_0000, 32'h0011_0000, 16, 210, 45, 1'b0, 1'b0);
    run_phase(32'h8000_0000, 32'h8004_0000, 64, 210, 35, 1'b0, 1'b1);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 24, 210, 50, 1'b1, 1'b0);
    run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 16, 210, 55, 1'b0, 1'b0);
    rbase  = $urandom_range(32'h000E_FFFF) << PAGE_SHIFT;
    rpages = $urandom_range(40, 1);
    run_phase(rbase, rbase + (rpages << PAGE_SHIFT), rpages, 210, 45, 1'b0, 1'b0);
    run_phase(32'h0030_0800, 32'h0031_0000, 16, 210, 45, 1'b0, 1'b0);
    run_phase(32'h0020_0000, 32'h0000_0000, 8, 100, 60, 1'b0, 1'b0);
    run_phase(32'h0040_0000, 32'h0040_4000, 4, 250, 65, 1'b0, 1'b0);

    settle_block();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
